// File: hdl/lces_pkg.sv
// Shared types and constants for the LRU chunk eviction selector.
package lces_pkg;

  localparam int NUM_CHUNKS = 256;
  localparam int IDX_W      = $clog2(NUM_CHUNKS);
  localparam int DIST_W     = 24;
  localparam int STAMP_W    = 32;
  localparam int FRAME_W    = 32;
  localparam int HYST_W     = 16;
  localparam int CNT_W      = 16;

  typedef logic [IDX_W-1:0] idx_t;

  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_TOUCH   = 2'd1,
    OP_ADVANCE = 2'd2,
    OP_EVICT   = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    ST_DONE          = 3'd0,
    ST_EVICT_HIDDEN  = 3'd1,
    ST_EVICT_VISIBLE = 3'd2,
    ST_SKIP_VISIBLE  = 3'd3,
    ST_NONE          = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_DECIDE
  } state_e;

  // Best candidate so far within one visibility class
  typedef struct packed {
    logic               found;
    idx_t               idx;
    logic [STAMP_W-1:0] stamp;
    logic [DIST_W-1:0]  distance;
  } best_t;

endpackage

// File: hdl/lru_chunk_eviction_selector.sv
// Chunk table with LRU eviction selection, visibility priority and load hysteresis.
//
// Write, touch and advance-frame commands never raise busy, and the result strobe done_o pulses in the
// following cycle. An eviction request scans the whole table through the entry memories, one
// entry per cycle, with a single shared compare unit, and holds busy through the scan, drain and
// decide states; its result strobe follows the decide state. The receiver cannot stall: done_o is
// high for a single cycle, and each result stays on the ports until the next command is accepted.
// The frame counters keep their value until the next command changes them. No clearing pass is
// needed after reset; per-entry flags and stamp-valid bits reset at once.
module lru_chunk_eviction_selector (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  opcode_i,
  input  logic [7:0]                  chunk_index_i,
  input  logic                        set_loaded_i,
  input  logic                        set_visible_i,
  input  logic [23:0]                 distance_i,
  input  logic                        allow_visible_i,
  input  logic                        cfg_we_i,
  input  logic [lces_pkg::HYST_W-1:0] cfg_wdata_i,
  output logic                        done_o,
  output logic [2:0]                  status_o,
  output logic [7:0]                  evicted_index_o,
  output logic [15:0]                 evictions_this_frame_o,
  output logic [15:0]                 visible_evictions_this_frame_o,
  output logic [31:0]                 use_stamp_o
);

  localparam int N = lces_pkg::NUM_CHUNKS;

  lces_pkg::state_e state_q, state_d;

  // Per-entry flags in flops
  logic [N-1:0] loaded_q, visible_q, snap_elig_q, snap_vis_q, stamp_vld_q;
  logic         snap_taken_q;

  logic [lces_pkg::STAMP_W-1:0] use_cnt_q;
  logic [lces_pkg::FRAME_W-1:0] frame_q;
  logic [lces_pkg::CNT_W-1:0]   evict_cnt_q, vis_cnt_q;
  logic [lces_pkg::HYST_W-1:0]  hyst_q;
  logic                         allow_q;

  // Entry memories
  logic [lces_pkg::DIST_W-1:0]  dist_mem  [N];
  logic [lces_pkg::STAMP_W-1:0] stamp_mem [N];
  logic [lces_pkg::FRAME_W-1:0] frame_mem [N];

  logic [lces_pkg::DIST_W-1:0]  dist_rd_q;
  logic [lces_pkg::STAMP_W-1:0] stamp_rd_q;
  logic [lces_pkg::FRAME_W-1:0] frame_rd_q;

  lces_pkg::idx_t scan_q, rd_idx_q;
  logic           rd_vld_q;

  lces_pkg::best_t best_hid_q, best_vis_q;

  logic                         done_q;
  lces_pkg::status_e            status_q;
  lces_pkg::idx_t               evicted_q;
  logic [lces_pkg::STAMP_W-1:0] stamp_out_q;

  // Command decode
  lces_pkg::opcode_e op;
  lces_pkg::idx_t    ci;
  logic              accept, in_range;
  logic              scan_last;

  assign op        = lces_pkg::opcode_e'(opcode_i);
  assign ci        = lces_pkg::idx_t'(chunk_index_i);
  assign accept    = start & ~busy;
  assign in_range  = int'(chunk_index_i) < N;
  assign scan_last = scan_q == lces_pkg::idx_t'(N - 1);

  logic [lces_pkg::STAMP_W-1:0] use_cnt_inc;
  assign use_cnt_inc = (use_cnt_q == '1) ? use_cnt_q : use_cnt_q + 1'b1;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lces_pkg::S_IDLE: begin
        if (accept && op == lces_pkg::OP_EVICT) state_d = lces_pkg::S_SCAN;
      end
      lces_pkg::S_SCAN: begin
        if (scan_last) state_d = lces_pkg::S_DRAIN;
      end
      lces_pkg::S_DRAIN:  state_d = lces_pkg::S_DECIDE;
      lces_pkg::S_DECIDE: state_d = lces_pkg::S_IDLE;
      default:            state_d = lces_pkg::S_IDLE;
    endcase
  end

  // FSM outputs
  logic scanning, deciding;
  always_comb begin
    busy     = 1'b1;
    scanning = 1'b0;
    deciding = 1'b0;
    unique case (state_q)
      lces_pkg::S_IDLE:   busy     = 1'b0;
      lces_pkg::S_SCAN:   scanning = 1'b1;
      lces_pkg::S_DRAIN:  ;
      lces_pkg::S_DECIDE: deciding = 1'b1;
      default:            busy     = 1'b1;
    endcase
  end

  // Compare stage: one entry per cycle against the best of its class
  logic                         cand_elig_now, cand_elig, cand_vis, cand_ok, better;
  logic [lces_pkg::FRAME_W-1:0] age;
  logic [lces_pkg::STAMP_W-1:0] cand_stamp;
  lces_pkg::best_t              sel_best, new_best;

  always_comb begin
    age           = frame_q - frame_rd_q;
    cand_elig_now = loaded_q[rd_idx_q] &&
                    !(hyst_q != '0 && age < lces_pkg::FRAME_W'(hyst_q));
    cand_elig     = snap_taken_q ? snap_elig_q[rd_idx_q] : cand_elig_now;
    cand_vis      = snap_taken_q ? snap_vis_q[rd_idx_q] : visible_q[rd_idx_q];
    cand_ok       = rd_vld_q && cand_elig && loaded_q[rd_idx_q];
    cand_stamp    = stamp_vld_q[rd_idx_q] ? stamp_rd_q : '0;
    sel_best      = cand_vis ? best_vis_q : best_hid_q;
    better        = !sel_best.found || cand_stamp < sel_best.stamp ||
                    (cand_stamp == sel_best.stamp && dist_rd_q > sel_best.distance);
    new_best.found    = 1'b1;
    new_best.idx      = rd_idx_q;
    new_best.stamp    = cand_stamp;
    new_best.distance = dist_rd_q;
  end

  // Decision at the end of the scan
  lces_pkg::status_e dec_status;
  lces_pkg::idx_t    dec_idx;
  logic              dec_evict, dec_vis;
  always_comb begin
    dec_status = lces_pkg::ST_NONE;
    dec_idx    = '0;
    dec_evict  = 1'b0;
    dec_vis    = 1'b0;
    if (best_hid_q.found) begin
      dec_status = lces_pkg::ST_EVICT_HIDDEN;
      dec_idx    = best_hid_q.idx;
      dec_evict  = 1'b1;
    end else if (best_vis_q.found) begin
      if (allow_q) begin
        dec_status = lces_pkg::ST_EVICT_VISIBLE;
        dec_idx    = best_vis_q.idx;
        dec_evict  = 1'b1;
        dec_vis    = 1'b1;
      end else begin
        dec_status = lces_pkg::ST_SKIP_VISIBLE;
      end
    end
  end

  // Control state and flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= lces_pkg::S_IDLE;
      loaded_q     <= '0;
      visible_q    <= '0;
      snap_elig_q  <= '0;
      snap_vis_q   <= '0;
      stamp_vld_q  <= '0;
      snap_taken_q <= 1'b0;
      use_cnt_q    <= '0;
      frame_q      <= '0;
      evict_cnt_q  <= '0;
      vis_cnt_q    <= '0;
      hyst_q       <= '0;
      scan_q       <= '0;
      rd_vld_q     <= 1'b0;
      done_q       <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= scanning;
      done_q   <= (accept && op != lces_pkg::OP_EVICT) || deciding;
      if (cfg_we_i) hyst_q <= cfg_wdata_i;
      if (scanning) scan_q <= scan_q + 1'b1;

      if (accept) begin
        case (op)
          lces_pkg::OP_WRITE: begin
            if (in_range) begin
              loaded_q[ci]  <= set_loaded_i;
              visible_q[ci] <= set_visible_i;
            end
          end
          lces_pkg::OP_TOUCH: begin
            if (in_range) begin
              use_cnt_q       <= use_cnt_inc;
              stamp_vld_q[ci] <= 1'b1;
            end
          end
          lces_pkg::OP_ADVANCE: begin
            frame_q      <= frame_q + 1'b1;
            evict_cnt_q  <= '0;
            vis_cnt_q    <= '0;
            snap_taken_q <= 1'b0;
          end
          default: scan_q <= '0;
        endcase
      end

      // Record the snapshot on the first request of the frame
      if (rd_vld_q && !snap_taken_q) begin
        snap_elig_q[rd_idx_q] <= cand_elig_now;
        snap_vis_q[rd_idx_q]  <= visible_q[rd_idx_q];
      end

      if (deciding) begin
        snap_taken_q <= 1'b1;
        if (dec_evict) begin
          loaded_q[dec_idx] <= 1'b0;
          if (evict_cnt_q != '1) evict_cnt_q <= evict_cnt_q + 1'b1;
          if (dec_vis && vis_cnt_q != '1) vis_cnt_q <= vis_cnt_q + 1'b1;
        end
      end
    end
  end

  // Entry memories: written only while idle, read during the scan
  always_ff @(posedge clk_i) begin
    if (accept && in_range && op == lces_pkg::OP_WRITE) begin
      dist_mem[ci] <= distance_i;
      if (set_loaded_i && !loaded_q[ci]) frame_mem[ci] <= frame_q;
    end
    if (accept && in_range && op == lces_pkg::OP_TOUCH) stamp_mem[ci] <= use_cnt_inc;
    dist_rd_q  <= dist_mem[scan_q];
    stamp_rd_q <= stamp_mem[scan_q];
    frame_rd_q <= frame_mem[scan_q];
  end

  // Scan datapath and result payload
  always_ff @(posedge clk_i) begin
    rd_idx_q <= scan_q;
    if (accept) begin
      allow_q          <= allow_visible_i;
      best_hid_q.found <= 1'b0;
      best_vis_q.found <= 1'b0;
      status_q         <= lces_pkg::ST_DONE;
      evicted_q        <= '0;
      stamp_out_q      <= (op == lces_pkg::OP_TOUCH && in_range) ? use_cnt_inc : '0;
    end
    if (cand_ok && better) begin
      if (cand_vis) best_vis_q <= new_best;
      else          best_hid_q <= new_best;
    end
    if (deciding) begin
      status_q  <= dec_status;
      evicted_q <= dec_idx;
    end
  end

  assign done_o                         = done_q;
  assign status_o                       = status_q;
  assign evicted_index_o                = 8'(evicted_q);
  assign evictions_this_frame_o         = evict_cnt_q;
  assign visible_evictions_this_frame_o = vis_cnt_q;
  assign use_stamp_o                    = stamp_out_q;

endmodule

// File: test/tb.sv
// Self-checking testbench for the LRU chunk eviction selector.
`timescale 1ns / 1ps

module tb;
  import lces_pkg::*;

  typedef struct packed {
    opcode_e           op;
    idx_t              index;
    logic              loaded;
    logic              visible;
    logic [DIST_W-1:0] distance;
    logic              allow;
  } command_t;

  typedef struct packed {
    status_e            status;
    idx_t               index;
    logic [CNT_W-1:0]   total;
    logic [CNT_W-1:0]   shown;
    logic [STAMP_W-1:0] stamp;
  } outcome_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [1:0]        opcode_i = '0;
  logic [7:0]        chunk_index_i = '0;
  logic              set_loaded_i = 1'b0;
  logic              set_visible_i = 1'b0;
  logic [23:0]       distance_i = '0;
  logic              allow_visible_i = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [HYST_W-1:0] cfg_wdata_i = '0;
  logic              done_o;
  logic [2:0]        status_o;
  logic [7:0]        evicted_index_o;
  logic [15:0]       evictions_this_frame_o;
  logic [15:0]       visible_evictions_this_frame_o;
  logic [31:0]       use_stamp_o;

  lru_chunk_eviction_selector i_dut (
    .clk_i                          (clk_i),
    .rst_ni                         (rst_ni),
    .start                          (start),
    .busy                           (busy),
    .opcode_i                       (opcode_i),
    .chunk_index_i                  (chunk_index_i),
    .set_loaded_i                   (set_loaded_i),
    .set_visible_i                  (set_visible_i),
    .distance_i                     (distance_i),
    .allow_visible_i                (allow_visible_i),
    .cfg_we_i                       (cfg_we_i),
    .cfg_wdata_i                    (cfg_wdata_i),
    .done_o                         (done_o),
    .status_o                       (status_o),
    .evicted_index_o                (evicted_index_o),
    .evictions_this_frame_o         (evictions_this_frame_o),
    .visible_evictions_this_frame_o (visible_evictions_this_frame_o),
    .use_stamp_o                    (use_stamp_o)
  );

  always #2 clk_i = ~clk_i;

  // Predicted chunk table and frame state
  bit                 ent_loaded  [NUM_CHUNKS];
  bit                 ent_visible [NUM_CHUNKS];
  bit [DIST_W-1:0]    ent_dist    [NUM_CHUNKS];
  bit [STAMP_W-1:0]   ent_stamp   [NUM_CHUNKS];
  bit [FRAME_W-1:0]   ent_frame   [NUM_CHUNKS];
  bit                 snap_ok     [NUM_CHUNKS];
  bit                 snap_shown  [NUM_CHUNKS];
  bit                 snap_valid;
  bit [STAMP_W-1:0]   stamp_count;
  bit [FRAME_W-1:0]   frame_no;
  bit [CNT_W-1:0]     evict_total;
  bit [CNT_W-1:0]     evict_shown;
  bit [HYST_W-1:0]    hyst_frames;

  command_t pending_commands[$];
  outcome_t expected_outcomes[$];

  bit          item_taken;
  bit          calm;
  int unsigned idle_left;
  int unsigned queued_count;
  int unsigned accepted_count;
  int unsigned result_count;
  int unsigned frame_advances;
  int unsigned mismatch_count;
  int unsigned status_seen[5];

  task automatic flag_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 40) $display("MISMATCH @%0t: %s", $realtime, what);
  endtask

  function automatic bit find_victim(input bit want_shown, output idx_t victim);
    bit                 found;
    bit [STAMP_W-1:0]   best_stamp;
    bit [DIST_W-1:0]    best_dist;
    found = 1'b0;
    victim = '0;
    best_stamp = '0;
    best_dist = '0;
    for (int i = 0; i < NUM_CHUNKS; i++) begin
      if (snap_ok[i] && snap_shown[i] == want_shown && ent_loaded[i]) begin
        if (!found || ent_stamp[i] < best_stamp ||
            (ent_stamp[i] == best_stamp && ent_dist[i] > best_dist)) begin
          found = 1'b1;
          victim = idx_t'(i);
          best_stamp = ent_stamp[i];
          best_dist = ent_dist[i];
        end
      end
    end
    return found;
  endfunction

  function automatic outcome_t predict_outcome(input command_t cmd);
    outcome_t res;
    idx_t     victim;
    res = '{status: ST_DONE, index: '0, total: '0, shown: '0, stamp: '0};
    case (cmd.op)
      OP_WRITE: begin
        if (cmd.loaded && !ent_loaded[cmd.index]) ent_frame[cmd.index] = frame_no;
        ent_loaded[cmd.index] = cmd.loaded;
        ent_visible[cmd.index] = cmd.visible;
        ent_dist[cmd.index] = cmd.distance;
      end
      OP_TOUCH: begin
        if (stamp_count != '1) stamp_count++;
        ent_stamp[cmd.index] = stamp_count;
        res.stamp = stamp_count;
      end
      OP_ADVANCE: begin
        frame_no++;
        evict_total = '0;
        evict_shown = '0;
        snap_valid = 1'b0;
      end
      default: begin
        // Eligibility and visibility are frozen by the first request of a frame
        if (!snap_valid) begin
          for (int i = 0; i < NUM_CHUNKS; i++) begin
            snap_ok[i] = ent_loaded[i] &&
                         !(hyst_frames != 0 && (frame_no - ent_frame[i]) < hyst_frames);
            snap_shown[i] = ent_visible[i];
          end
          snap_valid = 1'b1;
        end
        if (find_victim(1'b0, victim)) begin
          ent_loaded[victim] = 1'b0;
          res.status = ST_EVICT_HIDDEN;
          res.index = victim;
          if (evict_total != '1) evict_total++;
        end else if (find_victim(1'b1, victim)) begin
          if (cmd.allow) begin
            ent_loaded[victim] = 1'b0;
            res.status = ST_EVICT_VISIBLE;
            res.index = victim;
            if (evict_total != '1) evict_total++;
            if (evict_shown != '1) evict_shown++;
          end else begin
            res.status = ST_SKIP_VISIBLE;
          end
        end else begin
          res.status = ST_NONE;
        end
      end
    endcase
    res.total = evict_total;
    res.shown = evict_shown;
    return res;
  endfunction

  // Driver: hold each item until taken, then advance or idle for a burst
  always @(negedge clk_i) begin : drive_items
    command_t cmd;
    if (rst_ni && !(start && !item_taken)) begin
      if (idle_left != 0) begin
        idle_left <= idle_left - 1;
        start <= 1'b0;
      end else if (pending_commands.size() != 0) begin
        cmd = pending_commands.pop_front();
        opcode_i <= cmd.op;
        chunk_index_i <= cmd.index;
        set_loaded_i <= cmd.loaded;
        set_visible_i <= cmd.visible;
        distance_i <= cmd.distance;
        allow_visible_i <= cmd.allow;
        start <= 1'b1;
        if (!calm && $urandom_range(0, 5) == 0) idle_left <= $urandom_range(1, 14);
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: check the result of an earlier item, then predict any item taken now
  always @(posedge clk_i) begin : watch_results
    outcome_t want;
    item_taken = 1'b0;
    if (rst_ni) begin
      if (done_o === 1'b1) begin
        result_count++;
        if (expected_outcomes.size() == 0) begin
          flag_mismatch("result strobe with no item outstanding");
        end else begin
          want = expected_outcomes.pop_front();
          status_seen[want.status]++;
          if (status_o !== want.status)
            flag_mismatch($sformatf("status got %0d want %0d", status_o, want.status));
          if (evicted_index_o !== want.index)
            flag_mismatch($sformatf("evicted_index got %0d want %0d",
                                    evicted_index_o, want.index));
          if (evictions_this_frame_o !== want.total)
            flag_mismatch($sformatf("evictions_this_frame got %0d want %0d",
                                    evictions_this_frame_o, want.total));
          if (visible_evictions_this_frame_o !== want.shown)
            flag_mismatch($sformatf("visible_evictions_this_frame got %0d want %0d",
                                    visible_evictions_this_frame_o, want.shown));
          if (use_stamp_o !== want.stamp)
            flag_mismatch($sformatf("use_stamp got %0d want %0d", use_stamp_o, want.stamp));
        end
      end
      if (start && !busy) begin
        item_taken = 1'b1;
        accepted_count++;
        expected_outcomes.insert(expected_outcomes.size(),
            predict_outcome(command_t'({opcode_e'(opcode_i), chunk_index_i, set_loaded_i,
                                        set_visible_i, distance_i, allow_visible_i})));
      end
    end
  end

  task automatic queue_item(input opcode_e op, input int unsigned index, input bit loaded,
                            input bit visible, input int unsigned distance, input bit allow);
    command_t cmd;
    cmd.op = op;
    cmd.index = idx_t'(index);
    cmd.loaded = loaded;
    cmd.visible = visible;
    cmd.distance = distance[DIST_W-1:0];
    cmd.allow = allow;
    pending_commands.insert(pending_commands.size(), cmd);
    queued_count++;
    if (op == OP_ADVANCE) frame_advances++;
  endtask

  function automatic int unsigned pick_index();
    if ($urandom_range(0, 9) < 6) return $urandom_range(0, 31);
    return $urandom_range(0, NUM_CHUNKS - 1);
  endfunction

  // Half the distances come from a few fixed values so that ties occur
  function automatic int unsigned pick_distance();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 24'hFFFFFF;
      2: return 24'h000100;
      default: return $urandom_range(0, 24'hFFFFFF);
    endcase
  endfunction

  task automatic queue_noise();
    repeat ($urandom_range(1, 4))
      queue_item(opcode_e'($urandom_range(0, 3)), $urandom_range(0, NUM_CHUNKS - 1),
                 $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 24'hFFFFFF),
                 $urandom_range(0, 1));
  endtask

  // One frame: load and touch entries, request a few evictions, then advance
  task automatic queue_random_frame();
    repeat ($urandom_range(2, 12))
      queue_item(OP_WRITE, pick_index(), $urandom_range(0, 9) != 0, $urandom_range(0, 2) == 0,
                 pick_distance(), $urandom_range(0, 1));
    repeat ($urandom_range(0, 8))
      queue_item(OP_TOUCH, pick_index(), $urandom_range(0, 1), $urandom_range(0, 1),
                 $urandom_range(0, 24'hFFFFFF), $urandom_range(0, 1));
    repeat ($urandom_range(1, 4)) begin
      queue_item(OP_EVICT, $urandom_range(0, NUM_CHUNKS - 1), $urandom_range(0, 1),
                 $urandom_range(0, 1), $urandom_range(0, 24'hFFFFFF), $urandom_range(0, 1));
      // Change the table after the snapshot now and then
      if ($urandom_range(0, 3) == 0)
        queue_item(OP_WRITE, pick_index(), 1'b1, $urandom_range(0, 1), pick_distance(), 1'b0);
      if ($urandom_range(0, 3) == 0)
        queue_item(OP_TOUCH, pick_index(), 1'b0, 1'b0, 0, 1'b0);
    end
    if ($urandom_range(0, 4) == 0) queue_noise();
    queue_item(OP_ADVANCE, $urandom_range(0, NUM_CHUNKS - 1), $urandom_range(0, 1),
               $urandom_range(0, 1), $urandom_range(0, 24'hFFFFFF), $urandom_range(0, 1));
  endtask

  task automatic wait_drained();
    while (pending_commands.size() != 0 || start || expected_outcomes.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic set_hysteresis(input int unsigned frames);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= frames[HYST_W-1:0];
    @(posedge clk_i);
    hyst_frames = frames[HYST_W-1:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_random_phase(input int unsigned frames, input int unsigned n_items);
    int unsigned target;
    wait_drained();
    set_hysteresis(frames);
    target = queued_count + n_items;
    while (queued_count < target) queue_random_frame();
    wait_drained();
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Empty table, then a load that the frame's snapshot does not see
    queue_item(OP_EVICT, 0, 1'b0, 1'b0, 0, 1'b1);
    queue_item(OP_WRITE, 0, 1'b1, 1'b0, 0, 1'b0);
    queue_item(OP_EVICT, 0, 1'b0, 1'b0, 0, 1'b1);
    queue_item(OP_ADVANCE, 0, 1'b0, 1'b0, 0, 1'b0);
    // Stamp order, distance tie-break, index tie-break, visibility priority
    queue_item(OP_WRITE, 255, 1'b1, 1'b0, 24'hFFFFFF, 1'b0);
    queue_item(OP_WRITE, 7, 1'b1, 1'b0, 24'h000100, 1'b0);
    queue_item(OP_WRITE, 9, 1'b1, 1'b1, 24'hFFFFFF, 1'b0);
    queue_item(OP_WRITE, 3, 1'b1, 1'b1, 24'hFFFFFF, 1'b0);
    queue_item(OP_TOUCH, 0, 1'b0, 1'b0, 0, 1'b0);
    queue_item(OP_TOUCH, 255, 1'b0, 1'b0, 0, 1'b0);
    repeat (4) queue_item(OP_EVICT, 0, 1'b0, 1'b0, 0, 1'b0);
    queue_item(OP_EVICT, 0, 1'b0, 1'b0, 0, 1'b1);
    queue_item(OP_WRITE, 20, 1'b1, 1'b0, 24'h000ABC, 1'b0);
    queue_item(OP_EVICT, 0, 1'b0, 1'b0, 0, 1'b1);
    // Reloaded as hidden, but the snapshot still counts it visible
    queue_item(OP_WRITE, 9, 1'b1, 1'b0, 5, 1'b0);
    queue_item(OP_EVICT, 0, 1'b0, 1'b0, 0, 1'b0);
    queue_item(OP_ADVANCE, 0, 1'b0, 1'b0, 0, 1'b0);
    queue_item(OP_EVICT, 0, 1'b0, 1'b0, 0, 1'b0);
    queue_item(OP_WRITE, 9, 1'b0, 1'b0, 0, 1'b0);
    wait_drained();

    // Hysteresis holds a fresh load for two frames
    set_hysteresis(2);
    queue_item(OP_WRITE, 40, 1'b1, 1'b0, 24'h123456, 1'b0);
    queue_item(OP_EVICT, 0, 1'b0, 1'b0, 0, 1'b1);
    queue_item(OP_ADVANCE, 0, 1'b0, 1'b0, 0, 1'b0);
    queue_item(OP_EVICT, 0, 1'b0, 1'b0, 0, 1'b1);
    queue_item(OP_ADVANCE, 0, 1'b0, 1'b0, 0, 1'b0);
    queue_item(OP_EVICT, 0, 1'b0, 1'b0, 0, 1'b1);
    wait_drained();

    run_random_phase(1, 400);
    run_random_phase(65535, 120);
    run_random_phase(3, 400);
    run_random_phase($urandom_range(4, 40), 350);
    calm = 1'b1;
    run_random_phase(0, 430);

    repeat (NUM_CHUNKS + 8) @(posedge clk_i);
    if (expected_outcomes.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", expected_outcomes.size()));

    $display("Checked %0d results for %0d items over %0d frame advances",
             result_count, accepted_count, frame_advances);
    $display("Evictions: %0d hidden, %0d visible, %0d skipped as visible, %0d empty",
             status_seen[ST_EVICT_HIDDEN], status_seen[ST_EVICT_VISIBLE],
             status_seen[ST_SKIP_VISIBLE], status_seen[ST_NONE]);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("Timeout with %0d items queued and %0d results outstanding",
             pending_commands.size(), expected_outcomes.size());
    $display("TB_ERROR");
    $finish;
  end

endmodule
